// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules; only the controller includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: hw/rtl/svd_pkg.sv
// Types, constants and tables of the soft Viterbi de-interleaving decoder.
`timescale 1ns / 1ps
package svd_pkg;

  localparam int HISTORY_BITS = 8;
  localparam int EMIT_THRESH  = 8 + HISTORY_BITS;
  localparam int NSTATES      = 8;
  localparam int BLOCK_LEN    = 32;
  localparam int NSTEPS       = BLOCK_LEN / 2;
  localparam int OBUF_DEPTH   = 4;

  localparam logic [31:0] COST_MAX    = 32'h7fff_ffff;
  localparam logic [8:0]  BRANCH_SUM  = 9'd510;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [7:0]  LEN_RESET   = 8'd255;

  localparam logic [4:0] PAIR_ORDER [NSTEPS] = '{
    5'h1e, 5'h16, 5'h0e, 5'h06, 5'h1c, 5'h14, 5'h0c, 5'h04,
    5'h1a, 5'h12, 5'h0a, 5'h02, 5'h18, 5'h10, 5'h08, 5'h00
  };

  localparam logic [7:0] EXPECT_TAB [2 * NSTATES] = '{
    8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff,
    8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00
  };

  typedef struct packed {
    logic [7:0] soft_byte;
    logic       last_input;
  } svd_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_output;
  } svd_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       accept;
    logic       rd_lo;
    logic       rd_hi;
    logic       acs_init;
    logic       acs_en;
    logic       commit;
    logic       min_en;
    logic       emit;
    logic       finish;
    logic       drain;
    logic [3:0] step;
    logic [2:0] idx;
  } svd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic finished;
    logic trig;
    logic emit_ok;
    logic more_steps;
    logic has_out;
    logic drain_last;
  } svd_stat_t;

endpackage

// File: hw/rtl/svd_dp.sv
// Datapath: block store, shared add-compare-select unit, min search and result buffer.
`timescale 1ns / 1ps
module svd_dp import svd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wen,
  input  logic [7:0] cfg_wdata,
  input  svd_in_t   in_data,
  input  svd_cmd_t  cmd,
  output svd_stat_t stat,
  output svd_out_t  out_data
);

  logic [7:0]  mem [BLOCK_LEN];
  logic [7:0]  rdata;
  logic        pad;
  logic [4:0]  fill;
  logic [5:0]  filled;
  logic        last_r;
  logic [7:0]  s0, s1;
  logic [31:0] pcost [NSTATES];
  logic [15:0] surv  [NSTATES];
  logic [31:0] ncost [NSTATES];
  logic [15:0] nsurv [NSTATES];
  logic [11:0] sym, emitted;
  logic [7:0]  bytes_left, out_len;
  logic        finished;
  logic [2:0]  best;
  logic [31:0] best_cost;
  svd_out_t    obuf [OBUF_DEPTH];
  logic [2:0]  ocnt;
  logic [1:0]  rptr;

  logic [4:0]  pos, raddr;
  logic [4:0]  steps;
  logic [8:0]  bc;
  logic [15:0] hist;
  logic [2:0]  n0, n1;
  logic [31:0] c0, c1;
  logic [11:0] pend;
  logic        pend_lt8;
  logic [15:0] sv;
  logic [3:0]  drop;
  logic [15:0] shifted;
  logic [7:0]  bl_dec;

  assign pos   = PAIR_ORDER[cmd.step];
  assign raddr = cmd.rd_hi ? pos + 5'd1 : pos;
  assign steps = last_r ? 5'((filled + 6'd1) >> 1) : 5'(NSTEPS);

  // Branch metrics for the source state under service.
  assign bc   = 9'(s0 ^ EXPECT_TAB[{cmd.idx, 1'b0}]) + 9'(s1 ^ EXPECT_TAB[{cmd.idx, 1'b1}]);
  assign hist = {surv[cmd.idx][14:0], cmd.idx[0]};
  assign n0   = {cmd.idx[1:0], 1'b0};
  assign n1   = {cmd.idx[1:0], 1'b1};
  assign c0   = pcost[cmd.idx] + 32'(bc);
  assign c1   = pcost[cmd.idx] + 32'(BRANCH_SUM - bc);

  // Pending bits and output byte selection.
  assign pend     = sym - 12'd1 - emitted;
  assign pend_lt8 = $signed(pend) < $signed(12'd8);
  assign sv       = pend_lt8 ? {surv[best][14:0], best[0]} : surv[best];
  always_comb begin
    if (pend_lt8) begin
      drop = 4'd0;
    end else if ($signed(pend) > $signed(12'd16)) begin
      drop = 4'd8;
    end else begin
      drop = 4'(pend - 12'd8);
    end
  end
  assign shifted = sv >> drop;
  assign bl_dec  = bytes_left - 8'd1;

  assign stat.finished   = finished;
  assign stat.trig       = in_data.last_input || (fill == 5'(BLOCK_LEN - 1));
  assign stat.more_steps = (5'(cmd.step) + 5'd1) < steps;
  assign stat.emit_ok    = (ocnt < 3'(OBUF_DEPTH)) && !finished &&
                           (($signed(pend) >= $signed(12'(EMIT_THRESH))) ||
                            (last_r && !stat.more_steps && $signed(pend) > $signed(12'd0)));
  assign stat.has_out    = ocnt != 3'd0;
  assign stat.drain_last = {1'b0, rptr} == ocnt - 3'd1;
  assign out_data        = obuf[rptr];

  always_ff @(posedge clk) begin
    if (cmd.accept && !finished) begin
      mem[fill] <= in_data.soft_byte;
    end
    if (cmd.rd_lo || cmd.rd_hi) begin
      rdata <= mem[raddr];
      pad   <= {1'b0, raddr} >= filled;
    end
    if (cmd.rd_hi) begin
      s0 <= pad ? PAD_BYTE : rdata;
    end
    if (cmd.acs_init) begin
      s1 <= pad ? PAD_BYTE : rdata;
    end
    if (cmd.min_en) begin
      if (cmd.idx == 3'd0 || pcost[cmd.idx] < best_cost) begin
        best      <= cmd.idx;
        best_cost <= pcost[cmd.idx];
      end
    end
    if (cmd.acs_init) begin
      for (int s = 0; s < NSTATES; s++) begin
        ncost[s] <= COST_MAX;
        nsurv[s] <= surv[s];
      end
    end
    if (cmd.acs_en) begin
      if (c0 < ncost[n0]) begin
        ncost[n0] <= c0;
        nsurv[n0] <= hist;
      end
      if (c1 < ncost[n1]) begin
        ncost[n1] <= c1;
        nsurv[n1] <= hist;
      end
    end
    if (cmd.emit) begin
      obuf[ocnt[1:0]] <= '{data_byte: shifted[7:0], last_output: bl_dec == 8'd0};
    end
    if (cmd.finish && last_r && ocnt != 3'd0) begin
      obuf[2'(ocnt - 3'd1)].last_output <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_len    <= LEN_RESET;
      bytes_left <= LEN_RESET;
      fill       <= '0;
      filled     <= '0;
      last_r     <= 1'b0;
      sym        <= '0;
      emitted    <= '0;
      finished   <= 1'b0;
      ocnt       <= '0;
      rptr       <= '0;
      for (int s = 0; s < NSTATES; s++) begin
        pcost[s] <= (s == 0) ? 32'd0 : COST_MAX;
        surv[s]  <= '0;
      end
    end else begin
      if (cfg_wen) begin
        out_len <= cfg_wdata;
        if (fill == '0 && sym == '0 && emitted == '0 && !finished) begin
          bytes_left <= cfg_wdata;
        end
      end
      if (cmd.accept) begin
        if (!finished) begin
          fill   <= fill + 5'd1;
          filled <= 6'(fill) + 6'd1;
          last_r <= in_data.last_input;
        end
      end
      if (cmd.commit) begin
        for (int s = 0; s < NSTATES; s++) begin
          pcost[s] <= ncost[s];
          surv[s]  <= nsurv[s];
        end
        sym <= sym + 12'd1;
      end
      if (cmd.emit) begin
        surv[best] <= sv;
        bytes_left <= bl_dec;
        if (bl_dec == 8'd0) begin
          finished <= 1'b1;
        end
        emitted <= emitted + 12'd8;
        ocnt    <= ocnt + 3'd1;
      end
      if (cmd.drain) begin
        if (stat.drain_last) begin
          ocnt <= '0;
          rptr <= '0;
        end else begin
          rptr <= rptr + 2'd1;
        end
      end
      // Restart the packet on a final request or at the end of a final block.
      if ((cmd.accept && finished && in_data.last_input) || (cmd.finish && last_r)) begin
        fill       <= '0;
        sym        <= '0;
        emitted    <= '0;
        finished   <= 1'b0;
        bytes_left <= out_len;
        last_r     <= 1'b0;
        for (int s = 0; s < NSTATES; s++) begin
          pcost[s] <= (s == 0) ? 32'd0 : COST_MAX;
          surv[s]  <= '0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/svd_ctrl.sv
// Controller: sequences block reads, trellis steps, byte emission and result drain.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module svd_ctrl import svd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  svd_stat_t stat,
  output svd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_INIT, S_ACS, S_COMMIT, S_CHK, S_MIN, S_EMIT, S_END, S_DRAIN
  } state_t;

  state_t     state;
  logic [3:0] step;
  logic [2:0] idx;
  logic       in_acc, out_acc;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_DRAIN;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    cmd          = '0;
    cmd.step     = step;
    cmd.idx      = idx;
    cmd.accept   = in_acc;
    cmd.rd_lo    = state == S_RD0;
    cmd.rd_hi    = state == S_RD1;
    cmd.acs_init = state == S_INIT;
    cmd.acs_en   = state == S_ACS;
    cmd.commit   = state == S_COMMIT;
    cmd.min_en   = state == S_MIN;
    cmd.emit     = state == S_EMIT;
    cmd.finish   = state == S_END;
    cmd.drain    = out_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && !stat.finished && stat.trig) begin
            step  <= '0;
            state <= S_RD0;
          end
        end
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_INIT;
        S_INIT: begin
          idx   <= '0;
          state <= S_ACS;
        end
        S_ACS: begin
          idx <= idx + 3'd1;
          if (idx == 3'(NSTATES - 1)) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: state <= S_CHK;
        S_CHK: begin
          idx <= '0;
          if (stat.emit_ok) begin
            state <= S_MIN;
          end else if (stat.more_steps && !stat.finished) begin
            step  <= step + 4'd1;
            state <= S_RD0;
          end else begin
            state <= S_END;
          end
        end
        S_MIN: begin
          idx <= idx + 3'd1;
          if (idx == 3'(NSTATES - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: state <= S_CHK;
        S_END:  state <= stat.has_out ? S_DRAIN : S_IDLE;
        S_DRAIN: begin
          if (out_acc && stat.drain_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overlap, clk, rst, in_ready && out_valid, "request taken while draining")
  `ASSERT_CLK(a_idle_holds, clk, rst, (in_acc && (stat.finished || !stat.trig)) |=> in_ready, "ready dropped without block work")
  `ASSERT_CLK(a_drain_has_data, clk, rst, out_valid |-> stat.has_out, "drain with empty buffer")

endmodule

// File: hw/rtl/soft_viterbi_deinterleave_decoder_unit.sv
// Top level of the soft-decision de-interleaving K=4 rate-1/2 Viterbi decoder.
// Soft bytes are taken one per cycle while no block is being decoded. The byte that
// completes a 32-byte block, or carries last_input, starts decoding: each of up to 16
// trellis steps runs two block-store reads, a setup, a pass of the single shared
// add-compare-select unit for each of the eight states, a commit and a check, and each
// decoded byte adds a minimum-cost search over the eight states and an emit, before an
// end state. Up to four decoded bytes then drain one per cycle as out_ready allows; no
// request is taken until the drain finishes.
`timescale 1ns / 1ps
module soft_viterbi_deinterleave_decoder_unit import svd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  svd_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output svd_out_t   out_data
);

  svd_cmd_t  cmd;
  svd_stat_t stat;

  svd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  svd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
